@@ hw/rtl/twd_pkg.sv @@
// Package for the tilt wake detector: widths, register indexes, CORDIC angle table.
// No dependencies.
package twd_pkg;
	localparam int CordicStepsDef = 16;
	localparam int SampleBitsDef  = 16;
	localparam int AccW = 26;
	localparam int VecW = 50;
	localparam logic [1:0] REG_ON_ANGLE   = 2'd0;
	localparam logic [1:0] REG_ARM_ANGLE  = 2'd1;
	localparam logic [1:0] REG_HOLD_TICKS = 2'd2;

	function automatic logic [21:0] atan_entry(input logic [4:0] i);
		logic [21:0] r;
		begin
			case (i)
				5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
				5'd3: r = 22'd466945;   5'd4: r = 22'd234378;   5'd5: r = 22'd117304;
				5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
				5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
				5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
				5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
				5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
				5'd21: r = 22'd2;       5'd22: r = 22'd1;       default: r = 22'd0;
			endcase
			return r;
		end
	endfunction
endpackage

@@ hw/rtl/tilt_wake_detector.sv @@
// Tilt wake detector, top level: stream ports, configuration, light control.
// Uses twd_pkg, twd_sqrt and twd_cordic.
// One item at a time. A tick goes from ST_IDLE through ST_OUT to the output register. A sample
// runs a square root, then pitch and roll CORDIC passes on one shared vectoring unit,
// one step per cycle, and then goes through ST_OUT to the output register.
// The result waits in an output register; the next item is taken once it leaves.
module tilt_wake_detector import twd_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef,
	parameter int SAMPLE_BITS  = SampleBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // pitch, roll, light_on, turned_on, turned_off, zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int W = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_SQRT = 3'd1, ST_PITCH = 3'd2,
		ST_ROLL = 3'd3, ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic signed [15:0] on_q, arm_q, prev_q, pitch_q;
	logic [15:0] hold_q, cnt_q;
	logic signed [16:0] roll_q;
	logic light_q, ton_q, toff_q;
	logic signed [15:0] ax_q, ay_q, az_q, axw, ayw, azw;
	logic [16:0] root;
	logic sq_start, sq_done, co_start, co_done;
	logic signed [17:0] co_num, co_den, angle;
	logic signed [31:0] yy, zz;
	logic signed [15:0] p_cl;
	logic signed [16:0] r_cl;

	assign axw = 16'($signed(s_tdata[W-1:0]));
	assign ayw = 16'($signed(s_tdata[16+W-1:16]));
	assign azw = 16'($signed(s_tdata[32+W-1:32]));
	assign yy = ayw * ayw;
	assign zz = azw * azw;

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign sq_start = (state_q == ST_IDLE) && s_tvalid && s_tready && s_tuser;
	assign m_tdata = {4'd0, toff_q, ton_q, light_q, roll_q, pitch_q};

	twd_sqrt u_sqrt (.clk, .arst_n, .start(sq_start), .mag2(32'(yy) + 32'(zz)),
		.done(sq_done), .root);

	assign co_start = sq_done || (state_q == ST_PITCH && co_done);
	assign co_num = (state_q == ST_SQRT) ? 18'(ax_q) : 18'(ay_q);
	assign co_den = (state_q == ST_SQRT) ? $signed({1'b0, root}) : 18'(az_q);

	twd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.clk, .arst_n,
		.start(co_start), .num(co_num), .den(co_den), .done(co_done), .angle);

	assign p_cl = (angle > 18'sd23040) ? 16'sd23040 :
		(angle < -18'sd23040) ? -16'sd23040 : 16'(angle);
	assign r_cl = (angle > 18'sd46080) ? 17'sd46080 :
		(angle < -18'sd46080) ? -17'sd46080 : 17'(angle);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q   <= 16'sd7680;
			arm_q  <= 16'sd2560;
			hold_q <= 16'd4000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ON_ANGLE:   on_q   <= cfg_data;
				REG_ARM_ANGLE:  arm_q  <= cfg_data;
				REG_HOLD_TICKS: hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequence items and update light state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			light_q <= 1'b0;
			ton_q <= 1'b0;
			toff_q <= 1'b0;
			prev_q <= '0;
			cnt_q <= '0;
			pitch_q <= '0;
			roll_q <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					ton_q <= 1'b0;
					toff_q <= 1'b0;
					if (s_tuser) begin
						ax_q <= axw; ay_q <= ayw; az_q <= azw;
						state_q <= ST_SQRT;
					end else begin
						if (light_q) begin
							if ((cnt_q != 16'hFFFF ? cnt_q + 16'd1 : cnt_q) >= hold_q) begin
								light_q <= 1'b0;
								toff_q <= 1'b1;
							end
							if (cnt_q != 16'hFFFF) cnt_q <= cnt_q + 16'd1;
						end
						state_q <= ST_OUT;
					end
				end
				ST_SQRT: if (sq_done) state_q <= ST_PITCH;
				ST_PITCH: if (co_done) begin
					pitch_q <= p_cl;
					state_q <= ST_ROLL;
				end
				ST_ROLL: if (co_done) begin
					roll_q <= r_cl;
					prev_q <= pitch_q;
					if (!light_q && pitch_q >= on_q && prev_q <= arm_q) begin
						light_q <= 1'b1;
						cnt_q <= '0;
						ton_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/twd_sqrt.sv @@
// Digit-serial floor square root of y*y + z*z, two radicand bits per cycle.
// Uses twd_pkg.
module twd_sqrt import twd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] mag2,
	output logic        done,
	output logic [16:0] root
);
	logic [31:0] rad_q;
	logic [18:0] rem_q;
	logic [16:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [18:0] rem_sh, trial;

	assign rem_sh = {rem_q[16:0], rad_q[31:30]};
	assign trial  = {root_q, 2'b01};
	assign root   = root_q;

	// shift in one radicand digit pair and settle one root bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rad_q  <= mag2;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q <= {rad_q[29:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[15:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

@@ hw/rtl/twd_cordic.sv @@
// CORDIC vectoring unit: atan2(num, den) in 1/256 degree, one rotation per cycle.
// Uses twd_pkg for the angle table and widths.
module twd_cordic import twd_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [17:0] num,
	input  logic signed [17:0] den,
	output logic               done,
	output logic signed [17:0] angle
);
	localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	logic signed [VecW-1:0] x_q, y_q, x0, y0;
	logic signed [AccW-1:0] acc_q, acc0, tab;
	logic [4:0] i_q;
	logic       busy_q, zero_q, fin_q;
	logic signed [AccW-1:0] rnd;

	// quadrant fold into the right half plane
	always_comb begin
		x0 = VecW'(den) <<< 14;
		y0 = VecW'(num) <<< 14;
		acc0 = '0;
		if (den < 0) begin
			if (num >= 0) begin
				x0 = VecW'(num) <<< 14; y0 = -(VecW'(den) <<< 14); acc0 = AccW'(90*65536);
			end else begin
				x0 = -(VecW'(num) <<< 14); y0 = VecW'(den) <<< 14; acc0 = -AccW'(90*65536);
			end
		end
	end

	assign tab = AccW'(atan_entry(i_q));
	assign rnd = (acc_q >= 0) ? ((acc_q + AccW'(128)) >>> 8) : -((-acc_q + AccW'(128)) >>> 8);

	// rotate by one table angle per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done  <= 1'b0;
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				x_q    <= x0;
				y_q    <= y0;
				acc_q  <= acc0;
				zero_q <= (num == 0) && (den == 0);
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + (y_q >>> i_q); y_q <= y_q - (x_q >>> i_q); acc_q <= acc_q + tab;
				end else begin
					x_q <= x_q - (y_q >>> i_q); y_q <= y_q + (x_q >>> i_q); acc_q <= acc_q - tab;
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'(Steps - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				angle <= zero_q ? '0 : 18'(rnd);
				done  <= 1'b1;
			end
		end
	end
endmodule

@@ tb/tilt_wake_detector_tb.sv @@
// Testbench for tilt_wake_detector: directed and random samples and ticks
// checked against a behavioral tilt/backlight predictor. Depends on twd_pkg and the RTL.
`timescale 1ns / 100ps

module tilt_wake_detector_tb;
	import twd_pkg::*;

	localparam int STEPS = 16;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;
	localparam longint ARCTAN_STEP [24] = '{
		2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	typedef struct packed {
		logic        turned_off;
		logic        turned_on;
		logic        light_on;
		logic [16:0] roll;
		logic [15:0] pitch;
	} tilt_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // accel_x, accel_y, accel_z
	logic        s_tuser = 1'b0; // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // pitch, roll, light_on, turned_on, turned_off, zero fill
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state and register copies
	logic signed [15:0] on_thresh = 16'sd7680;
	logic signed [15:0] arm_thresh = 16'sd2560;
	logic [15:0]        hold_limit = 16'd4000;
	logic               lamp_on = 1'b0;
	logic signed [15:0] last_pitch = '0;
	logic [15:0]        ticks_held = '0;
	logic signed [15:0] kept_pitch = '0;
	logic signed [16:0] kept_roll = '0;

	tilt_result_t pending_angles[$];
	int  errors = 0;
	bit  quiet = 1'b0;
	int  rx_stall = 0;

	tilt_wake_detector dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint floor_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// CORDIC vectoring in 1/65536 degree, rounded to 1/256 degree
	function automatic longint arc_angle(longint num, longint den);
		longint x, y, t, acc, dx, dy;
		acc = 0;
		if (num == 0 && den == 0) return 0;
		x = den * 16384;
		y = num * 16384;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; acc = 90 * 65536;
			end else begin
				t = x; x = -y; y = t; acc = -90 * 65536;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; acc += ARCTAN_STEP[i];
			end else begin
				x -= dx; y += dy; acc -= ARCTAN_STEP[i];
			end
		end
		if (acc >= 0) return (acc + 128) / 256;
		return -((-acc + 128) / 256);
	endfunction

	function automatic longint clip(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// advance the light state for one item and return its result
	function automatic tilt_result_t predict_tilt(logic mode, logic [47:0] acc_in);
		tilt_result_t res;
		longint ax, ay, az, mag, p, rl;
		res = '0;
		if (mode == MODE_TICK) begin
			if (lamp_on) begin
				if (ticks_held != 16'hFFFF) ticks_held++;
				if (ticks_held >= hold_limit) begin
					lamp_on = 1'b0;
					res.turned_off = 1'b1;
				end
			end
		end else begin
			ax = longint'($signed(acc_in[15:0]));
			ay = longint'($signed(acc_in[31:16]));
			az = longint'($signed(acc_in[47:32]));
			mag = floor_root(longint'(ay * ay + az * az));
			p = clip(arc_angle(ax, mag), 23040);
			rl = clip(arc_angle(ay, az), 46080);
			if (!lamp_on && p >= longint'(on_thresh) && longint'(last_pitch) <= longint'(arm_thresh)) begin
				lamp_on = 1'b1;
				ticks_held = '0;
				res.turned_on = 1'b1;
			end
			last_pitch = p[15:0];
			kept_pitch = p[15:0];
			kept_roll = rl[16:0];
		end
		res.pitch = kept_pitch;
		res.roll = kept_roll;
		res.light_on = lamp_on;
		return res;
	endfunction

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_stall <= $urandom_range(1, 10) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		tilt_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[35:0];
			if (pending_angles.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors++;
			end else begin
				want = pending_angles.pop_front();
				if (got.pitch !== want.pitch) begin
					$error("pitch: expected %0d got %0d", $signed(want.pitch), $signed(got.pitch));
					errors++;
				end
				if (got.roll !== want.roll) begin
					$error("roll: expected %0d got %0d", $signed(want.roll), $signed(got.roll));
					errors++;
				end
				if (got.light_on !== want.light_on) begin
					$error("light_on: expected %0b got %0b", want.light_on, got.light_on);
					errors++;
				end
				if (got.turned_on !== want.turned_on) begin
					$error("turned_on: expected %0b got %0b", want.turned_on, got.turned_on);
					errors++;
				end
				if (got.turned_off !== want.turned_off) begin
					$error("turned_off: expected %0b got %0b", want.turned_off, got.turned_off);
					errors++;
				end
			end
		end
	end

	// offer one item, leave tvalid high after the handshake
	task automatic send_item(logic mode, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		pending_angles.push_back(predict_tilt(mode, {z, y, x}));
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// drop tvalid and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ON_ANGLE: on_thresh = val;
			REG_ARM_ANGLE: arm_thresh = val;
			REG_HOLD_TICKS: hold_limit = val;
			default: ;
		endcase
	endtask

	task automatic test_angle_extremes();
		send_tick();
		send_item(MODE_SAMPLE, 0, 0, 0);
		send_item(MODE_SAMPLE, 16'sh7FFF, 0, 0);
		send_item(MODE_SAMPLE, -16'sh8000, 0, 0);
		send_item(MODE_SAMPLE, 0, 16'sh7FFF, 16'sh7FFF);
		send_item(MODE_SAMPLE, -16'sh8000, -16'sh8000, -16'sh8000);
		send_item(MODE_SAMPLE, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
		send_item(MODE_SAMPLE, 0, 16'sh100, 0);
		send_item(MODE_SAMPLE, 0, -16'sh100, 0);
		send_item(MODE_SAMPLE, 0, 1, -1);
		send_item(MODE_SAMPLE, 0, -1, -1);
		send_item(MODE_SAMPLE, 1, 0, -16'sh8000);
		send_tick();
		drain();
	endtask

	// arm, turn on, hold out the tick count, turn off
	task automatic test_light_cycle();
		write_reg(REG_HOLD_TICKS, 16'd5);
		send_item(MODE_SAMPLE, -16'sd200, 0, 16'sd4000);
		send_item(MODE_SAMPLE, 16'sd4000, 0, 16'sd1000);
		send_item(MODE_SAMPLE, 16'sd4000, 0, 16'sd1000);
		repeat (6) send_tick();
		drain();
		// zero hold time turns off on the first tick
		write_reg(REG_HOLD_TICKS, 16'd0);
		send_item(MODE_SAMPLE, -16'sd200, 0, 16'sd4000);
		send_item(MODE_SAMPLE, 16'sd4000, 0, 16'sd1000);
		send_tick();
		send_tick();
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_ON_ANGLE, -16'sd23040);
		write_reg(REG_ARM_ANGLE, 16'sd23040);
		write_reg(REG_HOLD_TICKS, 16'd65535);
		write_reg(REG_SPARE, 16'hFFFF);
		send_item(MODE_SAMPLE, -16'sh8000, 0, 1);
		repeat (3) send_tick();
		drain();
		write_reg(REG_ON_ANGLE, 16'sd23040);
		write_reg(REG_ARM_ANGLE, -16'sd23040);
		write_reg(REG_HOLD_TICKS, 16'd1);
		send_item(MODE_SAMPLE, -16'sh8000, 0, 0);
		send_item(MODE_SAMPLE, 16'sh7FFF, 0, 0);
		send_tick();
		drain();
	endtask

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return 16'($urandom_range(0, 31)) - 16'sd16;
			default: return 16'($urandom);
		endcase
	endfunction

	// mostly arm/trigger/hold sequences, with random noise between
	task automatic test_random_phase(int count, logic [15:0] on_v, logic [15:0] arm_v,
			logic [15:0] hold_v);
		int sent;
		sent = 0;
		write_reg(REG_ON_ANGLE, on_v);
		write_reg(REG_ARM_ANGLE, arm_v);
		write_reg(REG_HOLD_TICKS, hold_v);
		while (sent < count) begin
			if ($urandom_range(0, 2) != 0) begin
				send_item(MODE_SAMPLE, -16'($urandom_range(0, 8000)), rand_axis(),
					16'($urandom_range(1000, 16000)));
				send_item(MODE_SAMPLE, 16'($urandom_range(0, 32767)), rand_axis(), rand_axis());
				repeat ($urandom_range(0, 12)) send_tick();
				sent += 8;
			end else begin
				if ($urandom_range(0, 1)) send_tick();
				else send_item(MODE_SAMPLE, rand_axis(), rand_axis(), rand_axis());
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_angle_extremes();
		test_light_cycle();
		test_register_extremes();
		test_random_phase(500, 16'd7680, 16'd2560, 16'd4);
		test_random_phase(500, 16'd2000, 16'd6000, 16'd9);
		test_random_phase(400, 16'd23040, -16'sd23040, 16'd1);
		test_random_phase(300, -16'sd23040, 16'd23040, 16'd3);
		quiet = 1'b1;
		test_random_phase(300, 16'd5000, 16'd0, 16'd6);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
